// ===== sv/abd_pkg.sv =====
// shared types, constants and letter mapping functions for the affine bigram decrypt unit
`default_nettype none

package abd_pkg;

  // modulus of the bigram space and alphabet size
  localparam int unsigned Modulus = 961;
  localparam int unsigned Letters = 31;

  // widths
  localparam int unsigned KeyW   = 10;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned IdxW   = 5;
  localparam int unsigned ProdW  = 2 * KeyW;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 3;

  // windows-1251 letter bytes
  localparam logic [ByteW-1:0] ByteBase     = 8'hE0;
  localparam logic [IdxW-1:0]  HardSignPos  = 5'd26;
  localparam logic [IdxW-1:0]  YeryPos      = 5'd27;
  localparam logic [IdxW-1:0]  SoftSignPos  = 5'd28;
  localparam logic [IdxW-1:0]  SoftSignIdx  = 5'd26;
  localparam logic [IdxW-1:0]  YeryIdx      = 5'd27;
  localparam logic [ByteW-1:0] SoftSignByte = 8'hFC;
  localparam logic [ByteW-1:0] YeryByte     = 8'hFB;

  // reciprocal for reduction modulo 961: floor(2^30 / 961)
  localparam int unsigned RedShift = 30;
  localparam int unsigned RedMulW  = 21;
  localparam logic [RedMulW-1:0] RedMul = 21'd1117317;

  // reciprocal for splitting by 31: floor(2^15 / 31)
  localparam int unsigned SplitShift = 15;
  localparam int unsigned SplitMulW  = 11;
  localparam logic [SplitMulW-1:0] SplitMul = 11'd1057;

  localparam logic [KeyW-1:0] ModulusK = KeyW'(Modulus);
  localparam logic [KeyW-1:0] LastMul  = KeyW'(Modulus - 1);

  // register map
  typedef enum logic [0:0] {
    REG_KEY_A = 1'b0,
    REG_KEY_B = 1'b1
  } abd_reg_t;

  // key material handed to the datapath
  typedef struct packed {
    logic [KeyW-1:0] inv;
    logic [KeyW-1:0] kb;
    logic            noinv;
  } abd_key_t;

  // status of the inverse search
  typedef struct packed {
    logic            busy;
    logic [KeyW-1:0] inv;
  } abd_inv_status_t;

  typedef struct packed {
    logic            ok;
    logic [IdxW-1:0] idx;
  } abd_letter_t;

  // reduce a 10-bit key into 0..960
  function automatic logic [KeyW-1:0] reduce_key(input logic [KeyW-1:0] k);
    logic [KeyW-1:0] r;
    r = (k >= ModulusK) ? (k - ModulusK) : k;
    return r;
  endfunction

  // byte to letter index; hard sign and non-letters are not ok
  function automatic abd_letter_t byte_to_index(input logic [ByteW-1:0] b);
    abd_letter_t     res;
    logic [IdxW-1:0] p;
    p       = b[IdxW-1:0];
    res.ok  = (b[ByteW-1:IdxW] == ByteBase[ByteW-1:IdxW]) && (p != HardSignPos);
    if (p < HardSignPos) begin
      res.idx = p;
    end else if (p == YeryPos) begin
      res.idx = YeryIdx;
    end else if (p == SoftSignPos) begin
      res.idx = SoftSignIdx;
    end else begin
      res.idx = p - 5'd1;
    end
    return res;
  endfunction

  // letter index back to byte
  function automatic logic [ByteW-1:0] index_to_byte(input logic [IdxW-1:0] idx);
    logic [ByteW-1:0] b;
    if (idx < SoftSignIdx) begin
      b = ByteBase + {3'b000, idx};
    end else if (idx == SoftSignIdx) begin
      b = SoftSignByte;
    end else if (idx == YeryIdx) begin
      b = YeryByte;
    end else begin
      b = ByteBase + {3'b000, idx} + 8'd1;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== sv/abd_if.sv =====
// request channel interfaces for ciphertext bigrams and plaintext results
`default_nettype none

interface abd_cipher_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_first;
  logic [7:0] cipher_second;

  modport source(output valid, output cipher_first, output cipher_second, input ready);
  modport sink(input valid, input cipher_first, input cipher_second, output ready);
endinterface

interface abd_plain_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_first;
  logic [7:0] plain_second;
  logic       bad_letter;
  logic       key_not_invertible;

  modport source(output valid, output plain_first, output plain_second,
                 output bad_letter, output key_not_invertible, input ready);
  modport sink(input valid, input plain_first, input plain_second,
               input bad_letter, input key_not_invertible, output ready);
endinterface

`default_nettype wire

// ===== sv/affine_bigram_decrypt_unit.sv =====
// top level: key registers, inverse search and decrypt pipeline
//
// Decrypts ciphertext bigrams of the 31-letter Windows-1251 Russian alphabet
// under an affine cipher modulo 961.
// cipher channel: one request carries two ciphertext letter bytes.
// plain channel: one request per input with the two plaintext bytes, zero when
//   either flag is set, plus bad_letter and key_not_invertible.
// APB port: key_a at byte address 0, key_b at address 4, both 10 bits.
// Each bigram passes the decode, multiply, estimate, reduce and split registers
//   in order before plain.valid rises. Throughput: one bigram per cycle while
//   no inverse search runs and the receiver is ready, set by the five-stage pipeline.
// Writing key_a starts a search for its inverse that steps through one
//   candidate a cycle, candidates 1 to 960; cipher.ready stays low meanwhile.
// Reset: key_a = 1, key_b = 0, inverse = 1, pipeline empty; an item can be
//   taken as soon as reset is released.
// When the receiver stalls, each stage holds its item and cipher.ready drops
//   once all five stages are full; nothing is lost or repeated.
`default_nettype none

module affine_bigram_decrypt_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  abd_cipher_if.sink                       cipher,
  abd_plain_if.source                      plain,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [abd_pkg::AddrW-1:0]   paddr,
  input  wire logic [abd_pkg::DataW-1:0]   pwdata,
  output logic      [abd_pkg::DataW-1:0]   prdata,
  output logic                             pready
);
  import abd_pkg::*;

  logic            [KeyW-1:0] key_a;
  logic            [KeyW-1:0] key_b;
  logic                       wr;
  abd_reg_t                   sel;
  abd_inv_status_t            inv_status;
  abd_key_t                   keys;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign sel    = abd_reg_t'(paddr[2]);

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_a <= KeyW'(1);
      key_b <= '0;
    end else if (wr) begin
      case (sel)
        REG_KEY_A: key_a <= pwdata[KeyW-1:0];
        REG_KEY_B: key_b <= pwdata[KeyW-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (sel)
      REG_KEY_A: prdata = {{(DataW-KeyW){1'b0}}, key_a};
      REG_KEY_B: prdata = {{(DataW-KeyW){1'b0}}, key_b};
      default:   prdata = '0;
    endcase
  end

  // inverse of key_a, recomputed after each write
  abd_inverse u_inverse (
    .clk    (clk),
    .rst    (rst),
    .start  (wr && sel == REG_KEY_A),
    .key    (pwdata[KeyW-1:0]),
    .status (inv_status)
  );

  assign keys.inv   = inv_status.inv;
  assign keys.kb    = reduce_key(key_b);
  assign keys.noinv = (inv_status.inv == '0);

  // decrypt pipeline
  abd_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .hold   (inv_status.busy),
    .keys   (keys),
    .cipher (cipher),
    .plain  (plain)
  );

`ifndef SYNTHESIS
  // no bigram is taken while the inverse is still being searched
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (cipher.valid && cipher.ready) |-> !inv_status.busy)
    else $error("bigram accepted during inverse search");

  // a flagged result carries zero bytes
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (plain.valid && (plain.bad_letter || plain.key_not_invertible)) |->
      (plain.plain_first == '0 && plain.plain_second == '0))
    else $error("flagged result with nonzero bytes");

  // a key_a write always starts a search on the next cycle
  a_search_starts: assert property (@(posedge clk) disable iff (rst)
    (wr && sel == REG_KEY_A) |=> inv_status.busy)
    else $error("inverse search did not start");
`endif

endmodule

`default_nettype wire

// ===== sv/abd_inverse.sv =====
// iterative search for the inverse of key_a modulo 961
`default_nettype none

module abd_inverse (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [abd_pkg::KeyW-1:0]   key,
  output abd_pkg::abd_inv_status_t        status
);
  import abd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } abd_inv_state_t;

  abd_inv_state_t  state;
  logic [KeyW-1:0] ka;
  logic [KeyW-1:0] acc;
  logic [KeyW-1:0] mult;
  logic [KeyW-1:0] inv;
  logic [KeyW:0]   acc_sum;
  logic [KeyW-1:0] acc_next;

  // acc steps through ka * mult modulo 961
  always_comb begin
    acc_sum  = {1'b0, acc} + {1'b0, ka};
    acc_next = (acc_sum >= {1'b0, ModulusK}) ? KeyW'(acc_sum - {1'b0, ModulusK})
                                             : acc_sum[KeyW-1:0];
  end

  // search sequencer; a new key restarts the search in any state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      inv   <= KeyW'(1);
    end else if (start) begin
      state <= ST_SEARCH;
    end else begin
      case (state)
        ST_IDLE: begin
        end
        ST_SEARCH: begin
          if (acc == KeyW'(1)) begin
            inv   <= mult;
            state <= ST_IDLE;
          end else if (mult == LastMul) begin
            inv   <= '0;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // search operands
  always_ff @(posedge clk) begin
    if (start) begin
      ka   <= reduce_key(key);
      acc  <= reduce_key(key);
      mult <= KeyW'(1);
    end else if (state == ST_SEARCH) begin
      acc  <= acc_next;
      mult <= mult + KeyW'(1);
    end
  end

  assign status.busy = (state != ST_IDLE);
  assign status.inv  = inv;

endmodule

`default_nettype wire

// ===== sv/abd_datapath.sv =====
// five-stage decrypt pipeline: decode, multiply, estimate, reduce, split
`default_nettype none

module abd_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            hold,
  input  wire abd_pkg::abd_key_t keys,
  abd_cipher_if.sink           cipher,
  abd_plain_if.source          plain
);
  import abd_pkg::*;

  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;
  logic take;

  // stage 1 registers
  logic [KeyW-1:0]  s1_diff;
  logic             s1_bad;
  logic             s1_noinv;
  // stage 2 registers
  logic [ProdW-1:0] s2_prod;
  logic             s2_zero;
  logic             s2_bad;
  logic             s2_noinv;
  // stage 3 registers
  logic [ProdW-1:0] s3_prod;
  logic [KeyW-1:0]  s3_q;
  logic             s3_zero;
  logic             s3_bad;
  logic             s3_noinv;
  // stage 4 registers
  logic [KeyW-1:0]  s4_x;
  logic             s4_zero;
  logic             s4_bad;
  logic             s4_noinv;
  // output registers
  logic [ByteW-1:0] s5_first;
  logic [ByteW-1:0] s5_second;
  logic             s5_bad;
  logic             s5_noinv;

  // flow control: a stage moves when it is empty or its successor moves
  assign en5  = !v5 || plain.ready;
  assign en4  = !v4 || en5;
  assign en3  = !v3 || en4;
  assign en2  = !v2 || en3;
  assign en1  = !v1 || en2;
  assign cipher.ready = en1 && !hold;
  assign take = cipher.valid && !hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= take;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // stage 1: letter decode, bigram value, subtract key_b modulo 961
  abd_letter_t     l1, l2;
  logic [KeyW:0]   y;
  logic [KeyW:0]   d;
  always_comb begin
    l1 = byte_to_index(cipher.cipher_first);
    l2 = byte_to_index(cipher.cipher_second);
    y  = ({1'b0, l1.idx, 5'b00000} - {6'b000000, l1.idx}) + {6'b000000, l2.idx};
    if (y >= {1'b0, keys.kb}) begin
      d = y - {1'b0, keys.kb};
    end else begin
      d = (y + {1'b0, ModulusK}) - {1'b0, keys.kb};
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_diff  <= d[KeyW-1:0];
      s1_bad   <= !(l1.ok && l2.ok);
      s1_noinv <= keys.noinv;
    end
  end

  // stage 2: multiply by the inverse
  always_ff @(posedge clk) begin
    if (en2) begin
      s2_prod  <= s1_diff * keys.inv;
      s2_zero  <= s1_bad || s1_noinv;
      s2_bad   <= s1_bad;
      s2_noinv <= s1_noinv;
    end
  end

  // stage 3: quotient estimate by reciprocal, low by at most one
  logic [ProdW+RedMulW-1:0] qwide;
  assign qwide = s2_prod * RedMul;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_prod  <= s2_prod;
      s3_q     <= qwide[RedShift +: KeyW];
      s3_zero  <= s2_zero;
      s3_bad   <= s2_bad;
      s3_noinv <= s2_noinv;
    end
  end

  // stage 4: remainder with one correction step
  logic [ProdW-1:0] qm;
  logic [ProdW-1:0] rem;
  logic [KeyW-1:0]  x;
  always_comb begin
    qm  = ProdW'(s3_q) * ProdW'(ModulusK);
    rem = s3_prod - qm;
    x   = (rem >= ProdW'(Modulus)) ? KeyW'(rem - ProdW'(Modulus)) : rem[KeyW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_x     <= x;
      s4_zero  <= s3_zero;
      s4_bad   <= s3_bad;
      s4_noinv <= s3_noinv;
    end
  end

  // stage 5: split by 31 and map back to bytes
  logic [KeyW+SplitMulW-1:0] swide;
  logic [IdxW-1:0]           hi_est;
  logic [KeyW-1:0]           lo_wide;
  logic [IdxW-1:0]           hi;
  logic [IdxW-1:0]           lo;
  always_comb begin
    swide   = s4_x * SplitMul;
    hi_est  = swide[SplitShift +: IdxW];
    lo_wide = s4_x - KeyW'(hi_est) * KeyW'(Letters);
    if (lo_wide >= KeyW'(Letters)) begin
      hi = hi_est + 5'd1;
      lo = IdxW'(lo_wide - KeyW'(Letters));
    end else begin
      hi = hi_est;
      lo = lo_wide[IdxW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_first  <= s4_zero ? '0 : index_to_byte(hi);
      s5_second <= s4_zero ? '0 : index_to_byte(lo);
      s5_bad    <= s4_bad;
      s5_noinv  <= s4_noinv;
    end
  end

  assign plain.valid              = v5;
  assign plain.plain_first        = s5_first;
  assign plain.plain_second       = s5_second;
  assign plain.bad_letter         = s5_bad;
  assign plain.key_not_invertible = s5_noinv;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// testbench for the affine bigram decrypt unit: decrypts each accepted bigram and checks it

module tb_top;
  import abd_pkg::*;

  localparam logic [7:0]  HardSign  = 8'hFA;
  localparam int unsigned Alpha     = 31;
  localparam int unsigned BigramMod = 31 * 31;
  localparam int unsigned HoldCycles = 400;

  typedef struct packed {
    logic       ok;
    logic [4:0] idx;
  } letter_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       bad;
    logic       noinv;
  } plain_t;

  logic             clk;
  logic             rst;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  abd_cipher_if cipher_ch();
  abd_plain_if  plain_ch();

  affine_bigram_decrypt_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .cipher  (cipher_ch),
    .plain   (plain_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // key registers as the block should hold them
  logic [9:0]  key_a_q = 10'd1;
  logic [9:0]  key_b_q = 10'd0;
  int unsigned inv_q   = 1;

  plain_t pending_plain[$];

  int   errors        = 0;
  int   n_sent        = 0;
  int   n_checked     = 0;
  int   n_bad_letter  = 0;
  int   n_noinv       = 0;
  int   n_settings    = 0;
  int   tx_gap_pct    = 0;
  int   rx_gap_pct    = 0;
  logic rx_hold       = 1'b0;

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // byte to alphabet position; hard sign and non-letters are rejected
  function automatic letter_t letter_of(input logic [7:0] b);
    letter_t    l;
    logic [4:0] pos;
    pos   = b[4:0];
    l.ok  = (b[7:5] == 3'b111) && (b != HardSign);
    case (pos)
      5'd26:   l.idx = 5'd0;
      5'd27:   l.idx = 5'd27;
      5'd28:   l.idx = 5'd26;
      5'd29, 5'd30, 5'd31: l.idx = pos - 5'd1;
      default: l.idx = pos;
    endcase
    return l;
  endfunction

  // alphabet position back to byte
  function automatic logic [7:0] letter_byte(input logic [4:0] idx);
    if (idx < 5'd26) return 8'hE0 + {3'b000, idx};
    if (idx == 5'd26) return 8'hFC;
    if (idx == 5'd27) return 8'hFB;
    return 8'hE1 + {3'b000, idx};
  endfunction

  // inverse modulo 961 by search, 0 when none exists
  function automatic int unsigned mod_inverse(input logic [9:0] a);
    int unsigned r;
    r = a % BigramMod;
    for (int unsigned k = 1; k < BigramMod; k++) begin
      if ((k * r) % BigramMod == 1) return k;
    end
    return 0;
  endfunction

  // plaintext bigram under the current keys
  function automatic plain_t decrypt_bigram(input logic [7:0] cf, input logic [7:0] cs);
    letter_t     l1;
    letter_t     l2;
    int unsigned y;
    int unsigned diff;
    int unsigned x;
    plain_t      p;
    l1      = letter_of(cf);
    l2      = letter_of(cs);
    p       = '0;
    p.bad   = !(l1.ok && l2.ok);
    p.noinv = (inv_q == 0);
    if (!p.bad && !p.noinv) begin
      y    = l1.idx * Alpha + l2.idx;
      diff = (y + BigramMod - key_b_q % BigramMod) % BigramMod;
      x    = (inv_q * diff) % BigramMod;
      p.first_byte  = letter_byte(5'(x / Alpha));
      p.second_byte = letter_byte(5'(x % Alpha));
    end
    return p;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 30) $display("mismatch at %0t: %s", $time, what);
  endtask

  // receiver side: random stalls, plus a forced hold-off
  initial begin
    int gap;
    gap = 0;
    plain_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        plain_ch.ready = 1'b0;
      end else if (gap > 0) begin
        plain_ch.ready = 1'b0;
        gap--;
      end else begin
        plain_ch.ready = 1'b1;
        if (rx_gap_pct > 0 && $urandom_range(0, 99) < rx_gap_pct) gap = gap_len();
      end
    end
  end

  // result checker: each plain request against the oldest pending bigram
  always @(posedge clk) begin
    plain_t want;
    if (!rst && plain_ch.valid && plain_ch.ready) begin
      if (pending_plain.size() == 0) begin
        report_mismatch("plain request with no bigram pending");
      end else begin
        want = pending_plain.pop_front();
        n_checked++;
        if (plain_ch.plain_first !== want.first_byte)
          report_mismatch($sformatf("plain_first %h, expected %h",
                                    plain_ch.plain_first, want.first_byte));
        if (plain_ch.plain_second !== want.second_byte)
          report_mismatch($sformatf("plain_second %h, expected %h",
                                    plain_ch.plain_second, want.second_byte));
        if (plain_ch.bad_letter !== want.bad)
          report_mismatch($sformatf("bad_letter %b, expected %b",
                                    plain_ch.bad_letter, want.bad));
        if (plain_ch.key_not_invertible !== want.noinv)
          report_mismatch($sformatf("key_not_invertible %b, expected %b",
                                    plain_ch.key_not_invertible, want.noinv));
      end
    end
  end

  // apb register write, setup then access
  task automatic apb_write(input abd_reg_t r, input logic [31:0] v);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = AddrW'({r, 2'b00});
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (r)
      REG_KEY_A: begin
        key_a_q = v[9:0];
        inv_q   = mod_inverse(v[9:0]);
      end
      REG_KEY_B: key_b_q = v[9:0];
      default: ;
    endcase
  endtask

  task automatic apb_read(input abd_reg_t r, output logic [31:0] v);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = AddrW'({r, 2'b00});
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    v = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_key_reg(input abd_reg_t r, input logic [9:0] want);
    logic [31:0] rd;
    apb_read(r, rd);
    if (rd !== {22'b0, want})
      report_mismatch($sformatf("%s reads %h, expected %h", r.name(), rd, want));
  endtask

  // drop valid and wait until every pending bigram has come out
  task automatic settle_pipeline();
    @(negedge clk);
    cipher_ch.valid = 1'b0;
    while (pending_plain.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // new key pair, written only with the pipeline empty; upper data bits are junk
  task automatic set_keys(input logic [9:0] a, input logic [9:0] b);
    settle_pipeline();
    apb_write(REG_KEY_A, ($urandom() & 32'hFFFF_FC00) | {22'b0, a});
    apb_write(REG_KEY_B, ($urandom() & 32'hFFFF_FC00) | {22'b0, b});
    check_key_reg(REG_KEY_A, a);
    check_key_reg(REG_KEY_B, b);
    n_settings++;
  endtask

  // offer one bigram and wait until it is taken
  task automatic send_bigram(input logic [7:0] cf, input logic [7:0] cs);
    int     gap;
    plain_t p;
    gap = (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) ? gap_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      cipher_ch.valid         = 1'b0;
      cipher_ch.cipher_first  = 8'($urandom());
      cipher_ch.cipher_second = 8'($urandom());
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cipher_ch.valid         = 1'b1;
    cipher_ch.cipher_first  = cf;
    cipher_ch.cipher_second = cs;
    @(posedge clk);
    while (!cipher_ch.ready) @(posedge clk);
    p = decrypt_bigram(cf, cs);
    pending_plain.push_back(p);
    n_sent++;
    if (p.bad) n_bad_letter++;
    if (p.noinv) n_noinv++;
  endtask

  // mostly two letters, some with one or both bytes arbitrary
  task automatic send_random_bigram();
    int         pick;
    logic [7:0] cf;
    logic [7:0] cs;
    pick = $urandom_range(0, 99);
    cf   = letter_byte(5'($urandom_range(0, 30)));
    cs   = letter_byte(5'($urandom_range(0, 30)));
    if (pick >= 95) begin
      cf = 8'($urandom_range(0, 255));
      cs = 8'($urandom_range(0, 255));
    end else if (pick >= 85) begin
      if (pick[0]) cf = 8'($urandom_range(0, 255));
      else cs = 8'($urandom_range(0, 255));
    end
    send_bigram(cf, cs);
  endtask

  // reset values of the keys and the identity decryption they give
  task automatic test_reset_keys();
    check_key_reg(REG_KEY_A, 10'd1);
    check_key_reg(REG_KEY_B, 10'd0);
    send_bigram(8'hE0, 8'hE0);
    send_bigram(8'hFF, 8'hFF);
    send_bigram(8'hFC, 8'hFB);
  endtask

  // alphabet edges, soft sign and yery, hard sign and non-letter bytes
  task automatic test_letter_edges();
    set_keys(10'd5, 10'd100);
    send_bigram(8'hE0, 8'hFF);
    send_bigram(8'hFF, 8'hE0);
    send_bigram(HardSign, 8'hE0);
    send_bigram(8'hE0, HardSign);
    send_bigram(8'hFB, 8'hFC);
    send_bigram(8'hFC, 8'hFB);
    send_bigram(8'hDF, 8'hE1);
    send_bigram(8'h00, 8'hFF);
    send_bigram(8'h7F, 8'h80);
    send_bigram(HardSign, HardSign);
  endtask

  // zero key, keys sharing a factor with 961, keys above 960
  task automatic test_degenerate_keys();
    set_keys(10'd0, 10'd0);
    send_bigram(8'hE0, 8'hE0);
    send_bigram(HardSign, 8'h00);
    set_keys(10'd992, 10'd17);
    send_bigram(8'hE3, 8'hF1);
    send_bigram(8'h10, 8'hE0);
    set_keys(10'd1023, 10'd1023);
    send_bigram(8'hFF, 8'hFF);
    send_bigram(8'hE0, 8'hE0);
    set_keys(10'd960, 10'd960);
    send_bigram(8'hFF, 8'hFF);
    send_bigram(8'hC0, 8'hE1);
  endtask

  // random bigram streams under a run of key settings and idle patterns
  task automatic test_random_stream();
    logic [9:0] a;
    logic [9:0] b;
    for (int seg = 0; seg < 9; seg++) begin
      case (seg)
        0: begin a = 10'd1;    b = 10'd0;    end
        1: begin a = 10'd960;  b = 10'd960;  end
        2: begin a = 10'd1023; b = 10'd1023; end
        3: begin a = 10'd0;    b = 10'($urandom_range(0, 1023)); end
        4: begin
          a = 10'(31 * $urandom_range(1, 33));
          b = 10'($urandom_range(0, 1023));
        end
        default: begin
          a = 10'($urandom_range(0, 1023));
          b = 10'($urandom_range(0, 1023));
        end
      endcase
      set_keys(a, b);
      tx_gap_pct = (seg % 3 == 0) ? 0 : 25;
      rx_gap_pct = (seg % 3 == 1) ? 0 : 25;
      repeat (160) send_random_bigram();
    end
  endtask

  // receiver holds off while bigrams keep coming, so the pipeline fills
  task automatic test_output_stall();
    set_keys(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    tx_gap_pct = 0;
    rx_gap_pct = 0;
    // first bigram goes in only once the inverse search is over
    send_random_bigram();
    fork
      begin
        rx_hold = 1'b1;
        repeat (HoldCycles) @(negedge clk);
        rx_hold = 1'b0;
      end
      begin
        repeat (200) send_random_bigram();
      end
    join
    tx_gap_pct = 25;
    rx_gap_pct = 25;
  endtask

  // sequence of tests
  initial begin
    rst                     = 1'b1;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    cipher_ch.valid         = 1'b0;
    cipher_ch.cipher_first  = 8'h00;
    cipher_ch.cipher_second = 8'h00;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_keys();
    test_letter_edges();
    test_degenerate_keys();
    test_random_stream();
    test_output_stall();
    settle_pipeline();

    $display("summary: %0d bigrams sent, %0d results checked, %0d key settings",
             n_sent, n_checked, n_settings);
    $display("summary: %0d with a non-letter byte, %0d under a key with no inverse",
             n_bad_letter, n_noinv);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("watchdog expired with %0d results pending", pending_plain.size());
    $display("tb_top: errors");
    $finish;
  end

endmodule
